FILE: src/fmgi_pkg.sv
// shared constants, register indexes and widths for the field map grid interpolator
package fmgi_pkg;

	localparam int POS_W   = 32;
	localparam int CFG_W   = 32;
	localparam int PTS_W   = 7;
	localparam int FIELD_W = 24;
	localparam int IDX_W   = 6;
	localparam int REGI_W  = 3;
	localparam int NODE_W  = 3 * FIELD_W;
	localparam int XY_W    = 2 * FIELD_W;

	localparam int X_POINTS_MAX_DEF = 64;
	localparam int Y_POINTS_MAX_DEF = 64;

	localparam logic signed [POS_W-1:0]   ORIGIN_RST    = '0;
	localparam logic [CFG_W-1:0]          INV_PITCH_RST = 32'd1310720;
	localparam logic [PTS_W-1:0]          POINTS_RST    = 7'd64;
	localparam logic signed [FIELD_W-1:0] SCALE_RST     = 24'sd65536;

	typedef enum logic [REGI_W-1:0] {
		REG_X_ORIGIN    = 3'd0,
		REG_Y_ORIGIN    = 3'd1,
		REG_X_INV_PITCH = 3'd2,
		REG_Y_INV_PITCH = 3'd3,
		REG_X_POINTS    = 3'd4,
		REG_Y_POINTS    = 3'd5,
		REG_FIELD_SCALE = 3'd6
	} reg_idx_t;

endpackage

FILE: src/fmgi_ifs.sv
// request and response channel interfaces
interface fmgi_req_if import fmgi_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic [IDX_W-1:0]          grid_col;
	logic [IDX_W-1:0]          grid_row;
	logic signed [FIELD_W-1:0] load_bx;
	logic signed [FIELD_W-1:0] load_by;
	logic signed [FIELD_W-1:0] load_bz;

	modport source(output valid, kind, pos_x, pos_y, grid_col, grid_row, load_bx, load_by,
		load_bz, input ready);
	modport sink(input valid, kind, pos_x, pos_y, grid_col, grid_row, load_bx, load_by,
		load_bz, output ready);
endinterface

interface fmgi_rsp_if import fmgi_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] field_x;
	logic signed [FIELD_W-1:0] field_y;
	logic signed [FIELD_W-1:0] field_z;
	logic                      outside;

	modport source(output valid, field_x, field_y, field_z, outside, input ready);
	modport sink(input valid, field_x, field_y, field_z, outside, output ready);
endinterface

FILE: src/fmgi_ram.sv
// generic single-write, single-read ram with registered read
module fmgi_ram #(
	parameter int W = 72,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: src/fmgi_axis.sv
// one axis: position to grid units, interior test, nearest and neighbour index, distance
module fmgi_axis import fmgi_pkg::*; #(
	parameter int PMAX = X_POINTS_MAX_DEF,
	localparam int IW = $clog2(PMAX)
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [POS_W-1:0] pos,
	input  logic signed [POS_W-1:0] origin,
	input  logic [CFG_W-1:0]        inv_pitch,
	input  logic [PTS_W-1:0]        points,
	output logic [IW-1:0]           near,
	output logic [IW-1:0]           nbr,
	output logic [CFG_W-1:0]        offset,
	output logic                    in_grid
);
	localparam logic [10:0] PMAX_C = 11'(PMAX);

	logic signed [POS_W:0] diff_s1;
	logic [2*CFG_W-1:0]    u_s2;
	logic                  neg_s2;
	logic [PTS_W-1:0]      n;
	logic [PTS_W-1:0]      nm2;
	logic [CFG_W-1:0]      hi;
	logic [CFG_W-1:0]      frac;
	logic [CFG_W-1:0]      jr;
	logic [IW-1:0]         j_c;
	logic [IW-1:0]         nb_c;
	logic [CFG_W-1:0]      d_c;
	logic                  in_c;

	always_comb begin
		n    = (11'(points) > PMAX_C) ? PMAX_C[PTS_W-1:0] : points;
		nm2  = n - 7'd2;
		hi   = u_s2[2*CFG_W-1:CFG_W];
		frac = u_s2[CFG_W-1:0];
		in_c = !neg_s2 && (n >= 7'd3) && (hi != '0) &&
			((hi < 32'(nm2)) || ((hi == 32'(nm2)) && (frac == '0)));
		// round to nearest node
		jr  = hi + 32'(frac[CFG_W-1]);
		j_c = jr[IW-1:0];
		if (frac[CFG_W-1]) begin
			nb_c = j_c - IW'(1);
			d_c  = ~frac + 32'd1;
		end else if (frac != '0) begin
			nb_c = j_c + IW'(1);
			d_c  = frac;
		end else begin
			nb_c = j_c - IW'(1);
			d_c  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= {pos[POS_W-1], pos} - {origin[POS_W-1], origin};
			neg_s2  <= diff_s1[POS_W];
			u_s2    <= diff_s1[POS_W-1:0] * inv_pitch;
			near    <= j_c;
			nbr     <= nb_c;
			offset  <= d_c;
			in_grid <= in_c;
		end
	end
endmodule

FILE: src/fmgi_lane.sv
// one field component: planar interpolation, gain, rounding and saturation
module fmgi_lane import fmgi_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [FIELD_W-1:0] b0,
	input  logic signed [FIELD_W-1:0] b1,
	input  logic signed [FIELD_W-1:0] b2,
	input  logic [CFG_W-1:0]          t,
	input  logic [CFG_W-1:0]          s,
	input  logic signed [FIELD_W-1:0] scale,
	output logic signed [FIELD_W-1:0] result
);
	logic signed [FIELD_W:0]   d1;
	logic signed [FIELD_W:0]   d2;
	logic signed [57:0]        p1_s5;
	logic signed [57:0]        p2_s5;
	logic signed [FIELD_W-1:0] b0_s5;
	logic signed [59:0]        sum;
	logic signed [27:0]        r_s6;
	logic signed [51:0]        prod_s7;
	logic signed [52:0]        rnd;
	logic signed [36:0]        q;
	logic signed [FIELD_W-1:0] sat;

	always_comb begin
		d1  = {b1[FIELD_W-1], b1} - {b0[FIELD_W-1], b0};
		d2  = {b2[FIELD_W-1], b2} - {b0[FIELD_W-1], b0};
		sum = $signed({{4{b0_s5[FIELD_W-1]}}, b0_s5, 32'd0}) + p1_s5 + p2_s5
			+ 60'sd2147483648;
		rnd = prod_s7 + 53'sd32768;
		q   = rnd[52:16];
		// clamp when the bits above the sign do not agree
		if ((q[36:23] == '0) || (q[36:23] == '1)) begin
			sat = q[FIELD_W-1:0];
		end else if (q[36]) begin
			sat = {1'b1, {(FIELD_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(FIELD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s5   <= d1 * $signed({1'b0, t});
			p2_s5   <= d2 * $signed({1'b0, s});
			b0_s5   <= b0;
			r_s6    <= sum[59:32];
			prod_s7 <= r_s6 * scale;
			result  <= sat;
		end
	end
endmodule

FILE: src/field_map_grid_interpolator_core.sv
// top level: config registers, load/query pipeline, replicated node table, output register
// a query passes stages s1 to s8 and then the output register before rsp.valid rises; a load gives no beat
// throughput: one beat per cycle while not stalled, loads and queries mixed, set by the table copies that give
// each of the three node reads its own read port
// stall: the whole pipeline holds only while its last stage and the output register are full
// and rsp is not ready; reset: config registers take their defaults and the pipeline empties,
// table contents stay undefined until loaded, with no clearing pass
module field_map_grid_interpolator_core import fmgi_pkg::*; #(
	parameter int X_POINTS_MAX = X_POINTS_MAX_DEF,
	parameter int Y_POINTS_MAX = Y_POINTS_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [REGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	fmgi_req_if.sink          req,
	fmgi_rsp_if.source        rsp
);
	localparam int DEPTH = X_POINTS_MAX * Y_POINTS_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(X_POINTS_MAX);
	localparam int YW    = $clog2(Y_POINTS_MAX);

	logic signed [POS_W-1:0]   x_org_q, y_org_q;
	logic [CFG_W-1:0]          x_inv_q, y_inv_q;
	logic [PTS_W-1:0]          x_pts_q, y_pts_q;
	logic signed [FIELD_W-1:0] scale_q;

	logic en, take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic kind_s1, kind_s2, kind_s3;
	logic [IDX_W-1:0] col_s1, col_s2, col_s3, row_s1, row_s2, row_s3;
	logic [NODE_W-1:0] node_s1, node_s2, node_s3;
	logic in_s4, in_s5, in_s6, in_s7, in_s8;
	logic [CFG_W-1:0] tx_s4, ty_s4;

	logic [XW-1:0] jn, jb;
	logic [YW-1:0] kn, kb;
	logic [CFG_W-1:0] tx, ty;
	logic inx, iny;

	logic [AW-1:0] a0, a1, a2, wa;
	logic ram_we;
	logic [NODE_W-1:0] d0;
	logic [XY_W-1:0] d1, d2;
	logic signed [FIELD_W-1:0] fx, fy, fz;
	logic out_valid_q;

	assign take   = v_s8 && (!out_valid_q || rsp.ready);
	assign en     = !v_s8 || take;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_org_q <= ORIGIN_RST;
			y_org_q <= ORIGIN_RST;
			x_inv_q <= INV_PITCH_RST;
			y_inv_q <= INV_PITCH_RST;
			x_pts_q <= POINTS_RST;
			y_pts_q <= POINTS_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_ORIGIN:    x_org_q <= cfg_data;
				REG_Y_ORIGIN:    y_org_q <= cfg_data;
				REG_X_INV_PITCH: x_inv_q <= cfg_data;
				REG_Y_INV_PITCH: y_inv_q <= cfg_data;
				REG_X_POINTS:    x_pts_q <= cfg_data[PTS_W-1:0];
				REG_Y_POINTS:    y_pts_q <= cfg_data[PTS_W-1:0];
				REG_FIELD_SCALE: scale_q <= cfg_data[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	fmgi_axis #(.PMAX(X_POINTS_MAX)) u_axis_x (
		.clk(clk), .en(en), .pos(req.pos_x), .origin(x_org_q), .inv_pitch(x_inv_q),
		.points(x_pts_q), .near(jn), .nbr(jb), .offset(tx), .in_grid(inx)
	);

	fmgi_axis #(.PMAX(Y_POINTS_MAX)) u_axis_y (
		.clk(clk), .en(en), .pos(req.pos_y), .origin(y_org_q), .inv_pitch(y_inv_q),
		.points(y_pts_q), .near(kn), .nbr(kb), .offset(ty), .in_grid(iny)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			// from here on only query beats travel
			v_s4 <= v_s3 && !kind_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= req.kind;
			col_s1  <= req.grid_col;
			row_s1  <= req.grid_row;
			node_s1 <= {req.load_bx, req.load_by, req.load_bz};
			kind_s2 <= kind_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			node_s2 <= node_s1;
			kind_s3 <= kind_s2;
			col_s3  <= col_s2;
			row_s3  <= row_s2;
			node_s3 <= node_s2;
			in_s4   <= inx && iny;
			tx_s4   <= tx;
			ty_s4   <= ty;
			in_s5   <= in_s4;
			in_s6   <= in_s5;
			in_s7   <= in_s6;
			in_s8   <= in_s7;
		end
	end

	// loads write in the same stage where queries read, so program order holds
	always_comb begin
		a0 = AW'(jn) * AW'(Y_POINTS_MAX) + AW'(kn);
		a1 = AW'(jb) * AW'(Y_POINTS_MAX) + AW'(kn);
		a2 = AW'(jn) * AW'(Y_POINTS_MAX) + AW'(kb);
		wa = AW'(col_s3) * AW'(Y_POINTS_MAX) + AW'(row_s3);
		ram_we = en && v_s3 && kind_s3 && (int'(col_s3) < X_POINTS_MAX) &&
			(int'(row_s3) < Y_POINTS_MAX);
	end

	// table copies: full node at the nearest node, bx/by at the two neighbours
	fmgi_ram #(.W(NODE_W), .DEPTH(DEPTH)) u_ram_near (
		.clk(clk), .we(ram_we), .waddr(wa), .wdata(node_s3),
		.re(en), .raddr(a0), .rdata(d0)
	);

	fmgi_ram #(.W(XY_W), .DEPTH(DEPTH)) u_ram_col (
		.clk(clk), .we(ram_we), .waddr(wa), .wdata(node_s3[NODE_W-1:FIELD_W]),
		.re(en), .raddr(a1), .rdata(d1)
	);

	fmgi_ram #(.W(XY_W), .DEPTH(DEPTH)) u_ram_row (
		.clk(clk), .we(ram_we), .waddr(wa), .wdata(node_s3[NODE_W-1:FIELD_W]),
		.re(en), .raddr(a2), .rdata(d2)
	);

	fmgi_lane u_lane_x (
		.clk(clk), .en(en), .b0(d0[NODE_W-1:XY_W]), .b1(d1[XY_W-1:FIELD_W]),
		.b2(d2[XY_W-1:FIELD_W]), .t(tx_s4), .s(ty_s4), .scale(scale_q), .result(fx)
	);

	fmgi_lane u_lane_y (
		.clk(clk), .en(en), .b0(d0[XY_W-1:FIELD_W]), .b1(d1[FIELD_W-1:0]),
		.b2(d2[FIELD_W-1:0]), .t(tx_s4), .s(ty_s4), .scale(scale_q), .result(fy)
	);

	// bz with equal corners passes the interpolation unchanged
	fmgi_lane u_lane_z (
		.clk(clk), .en(en), .b0(d0[FIELD_W-1:0]), .b1(d0[FIELD_W-1:0]),
		.b2(d0[FIELD_W-1:0]), .t(tx_s4), .s(ty_s4), .scale(scale_q), .result(fz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp.field_x <= in_s8 ? fx : '0;
			rsp.field_y <= in_s8 ? fy : '0;
			rsp.field_z <= in_s8 ? fz : '0;
			rsp.outside <= !in_s8;
		end
	end

	assign rsp.valid = out_valid_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !en) |=> v_s8)
		else $error("last stage lost a result while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (out_valid_q && !rsp.ready))
		else $error("pipeline stalled without a waiting output beat");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.outside) |->
		(rsp.field_x == '0 && rsp.field_y == '0 && rsp.field_z == '0))
		else $error("outside beat carries a nonzero field");

	a_no_write_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (v_s3 && kind_s3))
		else $error("table written outside a load beat");

	a_load_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !v_s4)
		else $error("load beat went on past the table stage");
endmodule
